// ----- rtl/ise_pkg.sv -----
// ============================================================================
// ise_pkg: shared definitions of the indexed stack engine
// Operation and status codes, field widths and the types carried along the
// chain of stack cells.
// ============================================================================
`default_nettype none

package ise_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int FUNC_W   = 2;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam logic [FUNC_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] OP_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] OP_PEEK   = 2'd2;
    localparam logic [FUNC_W-1:0] OP_CHANGE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    // Broadcast shift command for every cell
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [DATA_W-1:0] data;
    } cmd_t;

    // Probe walking down the chain toward the addressed entry
    typedef struct packed {
        logic              valid;
        logic              write;
        logic [POS_W-1:0]  cnt;
        logic [DATA_W-1:0] data;
    } probe_t;

    // Answer walking back up the chain toward the top cell
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } ret_t;

endpackage

`default_nettype wire

// ----- rtl/ise_if.sv -----
// ============================================================================
// ise_if: request and response channels of the indexed stack engine
// Valid/ready channels; an item moves at a clock edge with valid and ready high.
// ============================================================================
`default_nettype none

interface ise_req_if;
    import ise_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic signed [DATA_W-1:0] data_value;
    logic [POS_W-1:0]    position;

    modport source (output valid, output func, output data_value, output position,
                    input ready);
    modport sink   (input valid, input func, input data_value, input position,
                    output ready);
endinterface

interface ise_rsp_if;
    import ise_pkg::*;

    logic                valid;
    logic                ready;
    logic signed [DATA_W-1:0] result_value;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, output result_value, output status,
                    output fill_count, input ready);
    modport sink   (input valid, input result_value, input status,
                    input fill_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/indexed_stack_engine_unit.sv -----
// ============================================================================
// indexed_stack_engine_unit: bounded LIFO stack with indexed peek and change
// Top level: request decode, fill counter, result register and the cell chain.
// ============================================================================
// Usage:
//   req  (sink)  : func, data_value, position; one request per operation.
//   rsp  (source): result_value, status, fill_count; one response per request.
//   Push and pop shift the whole chain of DEPTH cells at once; the
//   response is registered and appears in the cycle after the request.
//   Peek and change send a probe down the chain one cell a cycle and the
//   answer comes back up one cell a cycle; a bad position, an overflow or
//   an underflow answers in the cycle after the request. Throughput: one
//   push or pop per cycle while responses are taken; a peek or change
//   holds off new requests until its answer is in the response register.
//   A new request is taken while the previous response is being taken in
//   the same cycle; while the receiver stalls the response holds and
//   req.ready stays low.
//   Reset clears the fill count, any probe in flight and the response valid;
//   the stored words are not cleared and are only read after a push wrote
//   them.
//   fill_count reports the low five bits of the entry count.
// ============================================================================
`default_nettype none

module indexed_stack_engine_unit #(
    parameter int DEPTH = ise_pkg::DEPTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ise_req_if.sink    req,
    ise_rsp_if.source  rsp
);
    import ise_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WAIT = 1'b1;

    logic                state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_value_reg, out_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [CW-1:0]       out_count_reg, out_count_next;

    logic                accept;
    logic                full;
    logic                empty;
    logic                pos_ok;
    logic [31:0]         count_wide;
    logic [31:0]         out_count_wide;

    cmd_t                cmd;
    probe_t              fwd   [DEPTH+1];
    ret_t                ret   [DEPTH+1];
    logic [DATA_W-1:0]   val   [DEPTH];

    assign count_wide = 32'(count_reg);
    assign full       = (count_wide == 32'(DEPTH));
    assign empty      = (count_reg == '0);
    assign pos_ok     = (req.position != '0) && (32'(req.position) <= count_wide);

    // Take a request only when no probe is out and the response slot frees
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    // Shift command for the chain
    always_comb
    begin
        cmd.push = accept && (req.func == OP_PUSH) && !full;
        cmd.pop  = accept && (req.func == OP_POP) && !empty;
        cmd.data = req.data_value;
    end

    // Probe injected at the top cell, already counted for the top entry
    always_comb
    begin
        fwd[0].valid = accept && ((req.func == OP_PEEK) || (req.func == OP_CHANGE))
                       && pos_ok;
        fwd[0].write = (req.func == OP_CHANGE);
        fwd[0].cnt   = req.position - POS_W'(1);
        fwd[0].data  = req.data_value;
    end

    assign ret[DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] up_value;
            logic [DATA_W-1:0] down_value;

            if (gi == 0)
            begin : g_top
                assign up_value = req.data_value;
            end
            else
            begin : g_mid_up
                assign up_value = val[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_bottom
                assign down_value = '0;
            end
            else
            begin : g_mid_down
                assign down_value = val[gi+1];
            end

            ise_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .value_up   (up_value),
                .value_down (down_value),
                .value      (val[gi]),
                .fwd_in     (fwd[gi]),
                .fwd_out    (fwd[gi+1]),
                .ret_in     (ret[gi+1]),
                .ret_out    (ret[gi])
            );
        end
    endgenerate

    // Decode, counter and response register
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        if (state_reg == S_WAIT)
        begin
            if (ret[0].valid)
            begin
                state_next      = S_IDLE;
                out_valid_next  = 1'b1;
                out_value_next  = ret[0].data;
                out_status_next = ST_OK;
                out_count_next  = count_reg;
            end
        end
        else if (accept)
        begin
            out_value_next  = '0;
            out_status_next = ST_OK;
            out_count_next  = count_reg;
            out_valid_next  = 1'b1;
            unique case (req.func)
                OP_PUSH:
                begin
                    if (full)
                    begin
                        out_status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        count_next     = count_reg + CW'(1);
                        out_count_next = count_reg + CW'(1);
                    end
                end
                OP_POP:
                begin
                    if (empty)
                    begin
                        out_status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        count_next     = count_reg - CW'(1);
                        out_count_next = count_reg - CW'(1);
                        out_value_next = val[0];
                    end
                end
                default:
                begin
                    if (pos_ok)
                    begin
                        // Hold the response until the probe answers
                        state_next     = S_WAIT;
                        out_valid_next = 1'b0;
                    end
                    else
                    begin
                        out_status_next = ST_RANGE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign out_count_wide   = 32'(out_count_reg);
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.fill_count   = out_count_wide[FILL_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/ise_cell.sv -----
// ============================================================================
// ise_cell: one entry of the stack chain
// Holds one word, shifts with its neighbors on push and pop, and serves the
// walking probe used by peek and change.
// ============================================================================
`default_nettype none

module ise_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ise_pkg::cmd_t   cmd,
    input  wire logic [31:0]     value_up,
    input  wire logic [31:0]     value_down,
    output logic [31:0]          value,
    input  wire ise_pkg::probe_t fwd_in,
    output ise_pkg::probe_t      fwd_out,
    input  wire ise_pkg::ret_t   ret_in,
    output ise_pkg::ret_t        ret_out
);
    import ise_pkg::*;

    logic [DATA_W-1:0] value_reg, value_next;
    probe_t            fwd_reg;
    ret_t              ret_reg, ret_next;
    logic              hit;

    assign hit = fwd_reg.valid && (fwd_reg.cnt == '0);

    always_comb
    begin
        priority if (cmd.push)
        begin
            value_next = value_up;
        end
        else if (cmd.pop)
        begin
            value_next = value_down;
        end
        else if (hit && fwd_reg.write)
        begin
            value_next = fwd_reg.data;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    // Launch the answer here on a hit, else relay the one from below
    always_comb
    begin
        if (hit)
        begin
            ret_next.valid = 1'b1;
            ret_next.data  = fwd_reg.write ? fwd_reg.data : value_reg;
        end
        else
        begin
            ret_next = ret_in;
        end
    end

    // Advance the probe one cell, counting down
    always_comb
    begin
        fwd_out       = fwd_reg;
        fwd_out.valid = fwd_reg.valid && (fwd_reg.cnt != '0);
        fwd_out.cnt   = fwd_reg.cnt - POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
            ret_reg <= '0;
        end
        else
        begin
            fwd_reg <= fwd_in;
            ret_reg <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value   = value_reg;
    assign ret_out = ret_reg;

endmodule

`default_nettype wire
